@@ src/b2g_pkg.sv @@
// Shared types, constants and the divide-by-six helper for the Bayer-to-grey
// half-scale block. No dependencies.
package b2g_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int LEFT_W      = 9;
    localparam int PAIR_W      = 10;
    localparam int SUM_W       = 11;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT_GREEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_HEIGHT     = 2'd2;

    localparam logic             TOP_LEFT_GREEN_RST = 1'b1;
    localparam logic [CFG_W-1:0] RAW_WIDTH_RST      = 13'd640;
    localparam logic [CFG_W-1:0] RAW_HEIGHT_RST     = 13'd480;
    localparam logic [CFG_W-1:0] MIN_SIZE           = 13'd2;

    // floor(x/6) = (x * 2731) >> 14, exact for x < 8192
    localparam int             DIV6_SHIFT = 14;
    localparam logic [11:0]    DIV6_MULT  = 12'd2731;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     wdata;
    } b2g_cfg_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] raw_pixel;
    } b2g_raw_t;

    typedef struct packed {
        logic [PIX_W-1:0] grey_pixel;
        logic             frame_last;
    } b2g_grey_t;

    // Right-hand sample of a horizontal pair, handed to the cell stage
    typedef struct packed {
        logic              is_write;  // even row: store the pair sum
        logic              last;      // bottom-right sample of the frame
        logic [PAIR_W-1:0] pair;      // weighted left + weighted right
    } b2g_pair_t;

    function automatic logic [PIX_W-1:0] div6(input logic [SUM_W-1:0] s);
        logic [SUM_W+12-1:0] prod;
        prod = {12'd0, s} * {{SUM_W{1'b0}}, DIV6_MULT};
        return prod[DIV6_SHIFT +: PIX_W];
    endfunction

endpackage

@@ src/b2g_stream_if.sv @@
// Valid/ready channel carrying one request of payload type T.
// Depends on nothing; payload types come from b2g_pkg at instantiation.
interface b2g_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/bayer_to_gray_half_scale_core.sv @@
// Bayer 2x2 binning to grey at half scale: top level.
// A grey request is registered in the cell stage, then in the result register.
// Throughput: one raw sample per cycle unless grey_out stalls, set by the single cell stage.
// Reset: config to order=green-first, 640x480; counters and pipeline valids cleared.
// The line store is not cleared; each entry is written on an even row before its sum is used.
// Depends on b2g_pkg, b2g_stream_if, b2g_front, b2g_line_mem, b2g_back.
module bayer_to_gray_half_scale_core
    import b2g_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    b2g_stream_if.sink   cfg,
    b2g_stream_if.sink   raw_in,
    b2g_stream_if.source grey_out
);

    // One line-store entry per horizontal pair of the widest frame
    localparam int CELL_W = (MAX_WIDTH > 3) ? $clog2(MAX_WIDTH / 2) : 1;

    // Front -> cell stage: right-hand sample of a pair with its pair sum
    logic              a_load;
    logic              a_ready;
    b2g_pair_t         a_req;
    logic [CELL_W-1:0] pair_idx;

    // Line store ports: read issued with every accepted sample, data ready
    // in the cycle the sample sits in the cell stage
    logic              rd_en;
    logic [PAIR_W-1:0] rd_data;
    logic              mem_we;
    logic [CELL_W-1:0] mem_addr;
    logic [PAIR_W-1:0] mem_wdata;

    b2g_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CELL_W     (CELL_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .raw_in   (raw_in),
        .a_ready  (a_ready),
        .a_load   (a_load),
        .a_req    (a_req),
        .pair_idx (pair_idx),
        .rd_en    (rd_en)
    );

    b2g_line_mem #(
        .ADDR_W (CELL_W)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (rd_en),
        .raddr (pair_idx),
        .rdata (rd_data)
    );

    // Even-row requests write the pair sum; odd-row requests add the stored
    // sum, divide by six and load the result register
    b2g_back #(
        .CELL_W (CELL_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_load    (a_load),
        .a_req     (a_req),
        .pair_idx  (pair_idx),
        .rd_data   (rd_data),
        .a_ready   (a_ready),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .grey_out  (grey_out)
    );

endmodule

@@ src/b2g_line_mem.sv @@
// Line store of weighted pair sums: one write port, one registered read port.
// Uses b2g_pkg.
module b2g_line_mem
    import b2g_pkg::*;
#(
    parameter int ADDR_W = 11
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [PAIR_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [PAIR_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [PAIR_W-1:0] line_mem [DEPTH];
    logic [PAIR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            line_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= line_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/b2g_front.sv @@
// Input side: configuration registers, raster counters, sample weighting and
// the left sample of each pair. Uses b2g_pkg and b2g_stream_if.
module b2g_front
    import b2g_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int CELL_W     = 11
)(
    input  logic              clk,
    input  logic              rst_n,
    b2g_stream_if.sink        cfg,
    b2g_stream_if.sink        raw_in,
    input  logic              a_ready,
    output logic              a_load,
    output b2g_pair_t         a_req,
    output logic [CELL_W-1:0] pair_idx,
    output logic              rd_en
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = (WSZ_W > CFG_W) ? WSZ_W : CFG_W;
    localparam int HCMP_W = (HSZ_W > CFG_W) ? HSZ_W : CFG_W;

    logic             tlg_reg, tlg_next;
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [LEFT_W-1:0] left_reg, left_next;

    logic              cfg_wr, size_wr, accept;
    logic [WCMP_W-1:0] width_ext;
    logic [HCMP_W-1:0] height_ext;
    logic [WSZ_W-1:0]  w_size, col_inc;
    logic [HSZ_W-1:0]  h_size, row_inc;
    logic              col_wrap, row_wrap, in_bounds;
    logic              light;
    logic [LEFT_W-1:0] wp;

    assign cfg.ready    = 1'b1;
    assign raw_in.ready = a_ready;
    assign cfg_wr  = cfg.valid;
    assign size_wr = cfg_wr && (cfg.data.index == REG_RAW_WIDTH ||
                                cfg.data.index == REG_RAW_HEIGHT);
    assign accept  = raw_in.valid && a_ready;

    // Frame size clamped to 2..MAX
    assign width_ext  = WCMP_W'(width_reg);
    assign height_ext = HCMP_W'(height_reg);
    assign w_size = (width_reg < MIN_SIZE) ? WSZ_W'(2) :
                    (width_ext > WCMP_W'(MAX_WIDTH)) ? WSZ_W'(MAX_WIDTH) :
                    WSZ_W'(width_ext);
    assign h_size = (height_reg < MIN_SIZE) ? HSZ_W'(2) :
                    (height_ext > HCMP_W'(MAX_HEIGHT)) ? HSZ_W'(MAX_HEIGHT) :
                    HSZ_W'(height_ext);

    assign col_inc  = WSZ_W'(col_reg) + WSZ_W'(1);
    assign row_inc  = HSZ_W'(row_reg) + HSZ_W'(1);
    assign col_wrap = (col_inc >= w_size);
    assign row_wrap = (row_inc >= h_size);
    // trailing odd column or row is outside every cell
    assign in_bounds = (col_reg[0] || !col_wrap) && (row_reg[0] || !row_wrap);

    // green sites carry weight 1, red/blue weight 2
    assign light = col_reg[0] ^ row_reg[0] ^ tlg_reg;
    assign wp    = light ? {1'b0, raw_in.data.raw_pixel} : {raw_in.data.raw_pixel, 1'b0};

    assign a_load         = accept && in_bounds && col_reg[0];
    assign a_req.is_write = !row_reg[0];
    assign a_req.pair     = PAIR_W'(left_reg) + PAIR_W'(wp);
    assign a_req.last     = (col_inc == {w_size[WSZ_W-1:1], 1'b0}) &&
                            (row_inc == {h_size[HSZ_W-1:1], 1'b0});
    assign pair_idx = CELL_W'(col_reg >> 1);
    assign rd_en    = accept;

    always_comb
    begin
        tlg_next    = tlg_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        if (cfg_wr)
        begin
            case (cfg.data.index)
                REG_TOP_LEFT_GREEN: tlg_next    = cfg.data.wdata[0];
                REG_RAW_WIDTH:      width_next  = cfg.data.wdata;
                REG_RAW_HEIGHT:     height_next = cfg.data.wdata;
                default:            ;
            endcase
        end
        if (size_wr)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end
        else if (accept)
        begin
            if (in_bounds && !col_reg[0])
            begin
                left_next = wp;
            end
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : ROW_W'(row_inc);
            end
            else
            begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlg_reg    <= TOP_LEFT_GREEN_RST;
            width_reg  <= RAW_WIDTH_RST;
            height_reg <= RAW_HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
        end
        else
        begin
            tlg_reg    <= tlg_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
        end
    end

    // raster position stays inside the clamped frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (WSZ_W'(col_reg) < w_size) && (HSZ_W'(row_reg) < h_size))
        else $error("raster counter outside frame");

    // the frame's last sample brings both counters back to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !size_wr && col_wrap && row_wrap |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap at end of frame");

    // the held left sample only moves on an accepted request or a size write
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept && !size_wr |=> $stable(left_reg))
        else $error("left sample changed without a request");

endmodule

@@ src/b2g_back.sv @@
// Cell stage and result register: stores even-row pair sums, completes
// odd-row cells and divides by six. Uses b2g_pkg and b2g_stream_if.
module b2g_back
    import b2g_pkg::*;
#(
    parameter int CELL_W = 11
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              a_load,
    input  b2g_pair_t         a_req,
    input  logic [CELL_W-1:0] pair_idx,
    input  logic [PAIR_W-1:0] rd_data,
    output logic              a_ready,
    output logic              mem_we,
    output logic [CELL_W-1:0] mem_addr,
    output logic [PAIR_W-1:0] mem_wdata,
    b2g_stream_if.source      grey_out
);

    logic              a_valid_reg, a_valid_next;
    b2g_pair_t         a_req_reg;
    logic [CELL_W-1:0] a_cell_reg;
    logic              out_valid_reg, out_valid_next;
    b2g_grey_t         out_reg;

    logic             out_free, out_load, a_adv;
    logic [SUM_W-1:0] sum;

    assign out_free = !out_valid_reg || grey_out.ready;
    assign out_load = a_valid_reg && !a_req_reg.is_write && out_free;
    assign a_adv    = a_valid_reg && (a_req_reg.is_write || out_free);
    assign a_ready  = !a_valid_reg || a_adv;

    assign mem_we    = a_valid_reg && a_req_reg.is_write;
    assign mem_addr  = a_cell_reg;
    assign mem_wdata = a_req_reg.pair;

    assign sum = SUM_W'(rd_data) + SUM_W'(a_req_reg.pair);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (grey_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_req_reg  <= a_req;
            a_cell_reg <= pair_idx;
        end
        if (out_load)
        begin
            out_reg.grey_pixel <= div6(sum);
            out_reg.frame_last <= a_req_reg.last;
        end
    end

    assign grey_out.valid = out_valid_reg;
    assign grey_out.data  = out_reg;

    // a cell whose result cannot leave stays parked in the cell stage
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_req_reg.is_write && out_valid_reg && !grey_out.ready
        |=> a_valid_reg)
        else $error("completed cell dropped under back-pressure");

    // a stalled grey request keeps its valid and its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !grey_out.ready |=> out_valid_reg && $stable(out_reg))
        else $error("grey request changed while stalled");

    // line store write and result load never come from the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && out_load))
        else $error("store write and result load collide");

endmodule
